// ----- design/card_frame_parser_tag_registers_macros.svh -----
// Assertion macros for the tag frame parser.
// Used by design files that check their own control logic; needs clk_i and rst_ni in scope.
`ifndef CARD_FRAME_PARSER_TAG_REGISTERS_MACROS_SVH
`define CARD_FRAME_PARSER_TAG_REGISTERS_MACROS_SVH

// same-cycle implication
`define CFP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/cfp_pkg.sv -----
// Shared types and constants of the tag frame parser.
// No dependencies; used by cfp_rx, cfp_mirror and the top level.
package cfp_pkg;

  localparam int unsigned BufDepth = 32;
  localparam int unsigned CountW   = $clog2(BufDepth + 1);
  localparam int unsigned WordCount = 12;
  localparam int unsigned PayCount  = 6;

  typedef enum logic [1:0] {
    KindByte = 2'd0,
    KindEof  = 2'd1,
    KindTick = 2'd2,
    KindRead = 2'd3
  } kind_e;

  localparam logic [7:0] StxByte = 8'h02;
  localparam logic [7:0] EtxByte = 8'h03;

  localparam logic [2:0] FlagHead = 3'b001;
  localparam logic [2:0] FlagSum  = 3'b010;
  localparam logic [2:0] FlagTail = 3'b100;
  localparam logic [2:0] FlagAll  = FlagHead | FlagSum | FlagTail;

  localparam logic [15:0] HoldTicksReset = 16'd3000;

  localparam logic [7:0] CardProx  = 8'h02;
  localparam logic [7:0] CardIcA   = 8'h01;
  localparam logic [7:0] CardIcB   = 8'h03;
  localparam logic [7:0] CardGen10 = 8'h10;
  localparam logic [7:0] CardGen11 = 8'h11;
  localparam logic [7:0] CardGen20 = 8'h20;
  localparam logic [7:0] CardGen21 = 8'h21;
  localparam logic [7:0] CardGen22 = 8'h22;
  localparam logic [7:0] CardGen30 = 8'h30;
  localparam logic [7:0] CardGen50 = 8'h50;
  localparam logic [7:0] CardGen51 = 8'h51;
  localparam logic [7:0] CardGenFf = 8'hFF;

  localparam logic [15:0] WordProxType = 16'h0001;
  localparam logic [15:0] WordIcType   = 16'h0002;
  localparam logic [15:0] WordPresent  = 16'h0001;

  localparam logic [4:0] RegGenLast   = 5'd3;
  localparam logic [4:0] RegMirFirst  = 5'd10;
  localparam logic [4:0] RegMirLast   = 5'd17;
  localparam logic [4:0] RegMirOffset = 5'd6;

  localparam int unsigned Led1Bit = 0;
  localparam int unsigned Led2Bit = 1;

  typedef struct packed {
    logic                 ok;
    logic [7:0]           card_type;
    logic [PayCount-1:0][7:0] payload;
  } rx_frame_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        frame_ok;
    logic        led1_on;
    logic        led2_on;
    logic        beep_start;
    logic        mirrors_cleared;
  } res_t;

endpackage

// ----- design/card_frame_parser_tag_registers.sv -----
// Tag frame parser top level: request register, frame checker, mirrors, result register.
// A request waits in the input stage, then its result is registered; one request per cycle
// while results are taken, and a stalled result holds one request in the input stage.
// All state is processed in the single input-to-result stage, so requests never interleave.
// Reset: asynchronous, clears frame state, mirrors, LEDs, timer; hold_ticks returns to 3000.
// Depends on cfp_pkg, cfp_rx, cfp_mirror and the assertion macro header.
`include "card_frame_parser_tag_registers_macros.svh"

module card_frame_parser_tag_registers (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [4:0]  reg_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] read_data_o,
  output logic        frame_ok_o,
  output logic        led1_on_o,
  output logic        led2_on_o,
  output logic        beep_start_o,
  output logic        mirrors_cleared_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);
  import cfp_pkg::*;

  logic        s1_valid_q, s1_valid_d;
  kind_e       kind_q;
  logic [7:0]  rx_byte_q;
  logic [4:0]  reg_index_q;
  logic        s1_adv;
  logic        in_acc;
  logic        out_valid_q, out_valid_d;
  res_t        res_q;
  res_t        res_d;
  logic [15:0] hold_ticks_q;
  rx_frame_t   frame;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;
  assign s1_valid_d = in_acc || (s1_valid_q && !s1_adv);
  assign out_valid_d = s1_adv || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      hold_ticks_q <= HoldTicksReset;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) hold_ticks_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q      <= kind_e'(kind_i);
      rx_byte_q   <= rx_byte_i;
      reg_index_q <= reg_index_i;
    end
    if (s1_adv) res_q <= res_d;
  end

  cfp_rx u_rx (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (s1_adv),
    .kind_i    (kind_q),
    .rx_byte_i (rx_byte_q),
    .frame_o   (frame)
  );

  cfp_mirror u_mirror (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (s1_adv),
    .kind_i       (kind_q),
    .reg_index_i  (reg_index_q),
    .hold_ticks_i (hold_ticks_q),
    .frame_i      (frame),
    .res_o        (res_d)
  );

  assign out_valid_o       = out_valid_q;
  assign read_data_o       = res_q.read_data;
  assign frame_ok_o        = res_q.frame_ok;
  assign led1_on_o         = res_q.led1_on;
  assign led2_on_o         = res_q.led2_on;
  assign beep_start_o      = res_q.beep_start;
  assign mirrors_cleared_o = res_q.mirrors_cleared;

  `CFP_ASSERT_NOW(a_clear_leds_off, out_valid_q && res_q.mirrors_cleared,
    !res_q.led1_on && !res_q.led2_on, "clear result with an LED still on")
  `CFP_ASSERT_NOW(a_ok_xor_clear, out_valid_q,
    !(res_q.frame_ok && res_q.mirrors_cleared), "frame ok and clear in one result")
  `CFP_ASSERT_NOW(a_stall_cause, !in_ready_o,
    s1_valid_q && out_valid_q && !out_ready_i, "input stalled without a held result")
  `CFP_ASSERT_NEXT(a_accept_held, in_valid_i && in_ready_o,
    s1_valid_q, "accepted request lost from input stage")

endmodule

// ----- design/cfp_rx.sv -----
// Byte collector and frame checker: header, length, running XOR and tail.
// Depends on cfp_pkg.
module cfp_rx (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  cfp_pkg::kind_e    kind_i,
  input  logic [7:0]        rx_byte_i,
  output cfp_pkg::rx_frame_t frame_o
);
  import cfp_pkg::*;

  logic [CountW-1:0]        count_q, count_d;
  logic [7:0]               len_q, len_d;
  logic [7:0]               xor_q, xor_d;
  logic [7:0]               type_q, type_d;
  logic [2:0]               flags_q, flags_d;
  logic [PayCount-1:0][7:0] pay_q, pay_d;
  logic [7:0]               pos;
  logic [7:0]               len_eff;
  logic [7:0]               pos_m4;

  always_comb begin
    count_d = count_q;
    len_d   = len_q;
    xor_d   = xor_q;
    type_d  = type_q;
    flags_d = flags_q;
    pay_d   = pay_q;
    pos     = 8'(count_q);
    len_eff = (pos == 8'd1) ? rx_byte_i : len_q;
    pos_m4  = pos - 8'd4;
    if (step_i) begin
      unique case (kind_i)
        KindByte: begin
          if (count_q < CountW'(BufDepth)) begin
            if (pos == 8'd0) begin
              if (rx_byte_i == StxByte) flags_d = flags_d | FlagHead;
            end else begin
              if (pos == 8'd1) len_d = rx_byte_i;
              if (pos == 8'd2) type_d = rx_byte_i;
              if (pos >= 8'd4 && pos <= 8'd9) pay_d[pos_m4[2:0]] = rx_byte_i;
              if (len_eff >= 8'd4) begin
                if (pos <= len_eff - 8'd3) xor_d = xor_q ^ rx_byte_i;
                if (pos == len_eff - 8'd2 && xor_q == rx_byte_i) flags_d = flags_d | FlagSum;
                if (pos == len_eff - 8'd1 && rx_byte_i == EtxByte) flags_d = flags_d | FlagTail;
              end
            end
            count_d = count_q + CountW'(1);
          end
        end
        KindEof: begin
          count_d = '0;
          len_d   = '0;
          xor_d   = '0;
          flags_d = '0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    frame_o.ok        = (count_q >= CountW'(4)) && (len_q >= 8'd4) &&
                        (len_q <= pos) && (flags_q == FlagAll);
    frame_o.card_type = type_q;
    frame_o.payload   = pay_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      len_q   <= '0;
      xor_q   <= '0;
      type_q  <= '0;
      flags_q <= '0;
      pay_q   <= '0;
    end else begin
      count_q <= count_d;
      len_q   <= len_d;
      xor_q   <= xor_d;
      type_q  <= type_d;
      flags_q <= flags_d;
      pay_q   <= pay_d;
    end
  end

endmodule

// ----- design/cfp_mirror.sv -----
// Tag register mirrors, LEDs and hold timer; builds the result of one request.
// Depends on cfp_pkg; takes the checked frame from cfp_rx.
module cfp_mirror (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  cfp_pkg::kind_e     kind_i,
  input  logic [4:0]         reg_index_i,
  input  logic [15:0]        hold_ticks_i,
  input  cfp_pkg::rx_frame_t frame_i,
  output cfp_pkg::res_t      res_o
);
  import cfp_pkg::*;

  logic [WordCount-1:0][15:0] tag_q, tag_d;
  logic [1:0]                 ind_q, ind_d;
  logic                       hold_q, hold_d;
  logic [15:0]                elapsed_q, elapsed_d;
  logic [15:0]                elapsed_inc;
  logic [15:0]                rd_word;
  logic [4:0]                 mir_index;
  logic [PayCount-1:0][7:0]   p;

  assign p           = frame_i.payload;
  assign elapsed_inc = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;
  assign mir_index   = reg_index_i - RegMirOffset;

  always_comb begin
    rd_word = '0;
    if (reg_index_i <= RegGenLast) begin
      rd_word = tag_q[reg_index_i[3:0]];
    end else if (reg_index_i >= RegMirFirst && reg_index_i <= RegMirLast) begin
      rd_word = tag_q[mir_index[3:0]];
    end
  end

  always_comb begin
    tag_d     = tag_q;
    ind_d     = ind_q;
    hold_d    = hold_q;
    elapsed_d = elapsed_q;
    res_o     = '0;
    if (step_i) begin
      unique case (kind_i)
        KindEof: begin
          if (frame_i.ok) begin
            res_o.frame_ok   = 1'b1;
            res_o.beep_start = 1'b1;
            elapsed_d        = '0;
            hold_d           = 1'b1;
            case (frame_i.card_type) inside
              CardProx: begin
                tag_d[4]  = WordPresent;
                tag_d[5]  = {8'h00, p[1]};
                tag_d[6]  = {p[2], p[3]};
                tag_d[7]  = {p[4], p[5]};
                tag_d[0]  = WordProxType;
                tag_d[1]  = {8'h00, p[1]};
                tag_d[2]  = {p[2], p[3]};
                tag_d[3]  = {p[4], p[5]};
                ind_d     = 2'b01;
              end
              CardIcA, CardIcB: begin
                tag_d[8]  = WordPresent;
                tag_d[9]  = '0;
                tag_d[10] = {p[1], p[2]};
                tag_d[11] = {p[3], p[4]};
                tag_d[0]  = WordIcType;
                tag_d[1]  = '0;
                tag_d[2]  = {p[1], p[2]};
                tag_d[3]  = {p[3], p[4]};
                ind_d[Led2Bit] = 1'b1;
              end
              CardGen10, CardGen11, CardGen20, CardGen21, CardGen22,
              CardGen30, CardGen50, CardGen51, CardGenFf: begin
                tag_d[0]  = {8'h00, frame_i.card_type};
                tag_d[2]  = {p[0], p[1]};
                tag_d[3]  = {p[2], p[3]};
              end
              default: ;
            endcase
          end
        end
        KindTick: begin
          if (hold_q) begin
            elapsed_d = elapsed_inc;
            if (elapsed_inc >= hold_ticks_i) begin
              tag_d                 = '0;
              ind_d                 = '0;
              hold_d                = 1'b0;
              res_o.mirrors_cleared = 1'b1;
            end
          end
        end
        KindRead: res_o.read_data = rd_word;
        default: ;
      endcase
    end
    res_o.led1_on = ind_d[Led1Bit];
    res_o.led2_on = ind_d[Led2Bit];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q     <= '0;
      ind_q     <= '0;
      hold_q    <= 1'b0;
      elapsed_q <= '0;
    end else begin
      tag_q     <= tag_d;
      ind_q     <= ind_d;
      hold_q    <= hold_d;
      elapsed_q <= elapsed_d;
    end
  end

endmodule

// ----- dv/card_frame_parser_tag_registers_tb.sv -----
`timescale 1ns / 1ps
// Testbench for card_frame_parser_tag_registers: a directed table, then three random phases.
// Untyped results are checked by a predictor of the frame checker, mirrors and hold timer.
// Depends on cfp_pkg and the card_frame_parser_tag_registers RTL.
module card_frame_parser_tag_registers_tb;
  import cfp_pkg::*;

  localparam logic [4:0] FlNone = 5'b00000;
  localparam logic [4:0] FlOk   = 5'b10000;
  localparam logic [4:0] FlLed1 = 5'b01000;
  localparam logic [4:0] FlBeep = 5'b00010;
  localparam logic [4:0] FlClr  = 5'b00001;

  localparam int unsigned WType    = 0;
  localparam int unsigned WAux     = 1;
  localparam int unsigned WHi      = 2;
  localparam int unsigned WLo      = 3;
  localparam int unsigned ProxBase = RegMirFirst - RegMirOffset;
  localparam int unsigned IcBase   = ProxBase + 4;

  localparam int unsigned RandPerPhase = 570;
  localparam int unsigned DirRows      = 26;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic [4:0] idx;
    logic       typed;
    res_t       want;
  } request_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [1:0]  kind_i      = KindByte;
  logic [7:0]  rx_byte_i   = '0;
  logic [4:0]  reg_index_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] read_data_o;
  logic        frame_ok_o;
  logic        led1_on_o;
  logic        led2_on_o;
  logic        beep_start_o;
  logic        mirrors_cleared_o;
  logic        cfg_we_i    = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  int unsigned rx_count;
  logic [7:0]  rx_len;
  logic [7:0]  rx_xor;
  logic [7:0]  rx_card;
  logic [2:0]  rx_flags;
  logic [7:0]  rx_pay [PayCount];
  logic [15:0] tag_mirror [WordCount];
  logic [1:0]  led_state;
  logic        hold_on;
  logic [15:0] hold_elapsed;
  logic [15:0] hold_limit;

  request_t    request_q [$];
  res_t        pending_results [$];
  res_t        head_result;
  int unsigned error_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned stall_req = 0;
  int unsigned stall_left = 0;

  logic [7:0] other_cards [9] = '{CardGen10, CardGen11, CardGen20, CardGen21, CardGen22,
                                  CardGen30, CardGen50, CardGen51, CardGenFf};

  request_t dir_table [DirRows] = '{
    '{KindRead, 8'h00, 5'd0,  1'b1, {16'h0000, FlNone}},
    '{KindRead, 8'hFF, 5'd31, 1'b1, {16'h0000, FlNone}},
    '{KindTick, 8'h00, 5'd0,  1'b1, {16'h0000, FlNone}},
    '{KindEof,  8'h00, 5'd0,  1'b1, {16'h0000, FlNone}},
    '{KindByte, 8'h02, 5'd31, 1'b0, {16'h0000, FlNone}},
    '{KindByte, 8'h04, 5'd0,  1'b0, {16'h0000, FlNone}},
    '{KindByte, 8'h04, 5'd0,  1'b0, {16'h0000, FlNone}},
    '{KindByte, 8'h03, 5'd0,  1'b0, {16'h0000, FlNone}},
    '{KindEof,  8'hFF, 5'd31, 1'b1, {16'h0000, FlOk | FlBeep}},
    '{KindTick, 8'h00, 5'd0,  1'b1, {16'h0000, FlClr}},
    '{KindByte, 8'h02, 5'd0,  1'b0, {16'h0000, FlNone}},
    '{KindByte, 8'h0C, 5'd0,  1'b0, {16'h0000, FlNone}},
    '{KindByte, 8'h02, 5'd0,  1'b0, {16'h0000, FlNone}},
    '{KindByte, 8'hFF, 5'd0,  1'b0, {16'h0000, FlNone}},
    '{KindByte, 8'h11, 5'd0,  1'b0, {16'h0000, FlNone}},
    '{KindByte, 8'h22, 5'd0,  1'b0, {16'h0000, FlNone}},
    '{KindByte, 8'h33, 5'd0,  1'b0, {16'h0000, FlNone}},
    '{KindByte, 8'h44, 5'd0,  1'b0, {16'h0000, FlNone}},
    '{KindByte, 8'h55, 5'd0,  1'b0, {16'h0000, FlNone}},
    '{KindByte, 8'h66, 5'd0,  1'b0, {16'h0000, FlNone}},
    '{KindByte, 8'h86, 5'd0,  1'b0, {16'h0000, FlNone}},
    '{KindByte, 8'h03, 5'd0,  1'b0, {16'h0000, FlNone}},
    '{KindEof,  8'h00, 5'd0,  1'b1, {16'h0000, FlOk | FlLed1 | FlBeep}},
    '{KindRead, 8'h00, 5'd12, 1'b0, {16'h0000, FlNone}},
    '{KindTick, 8'h00, 5'd0,  1'b1, {16'h0000, FlClr}},
    '{KindRead, 8'h00, 5'd0,  1'b1, {16'h0000, FlNone}}
  };

  card_frame_parser_tag_registers dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .kind_i            (kind_i),
    .rx_byte_i         (rx_byte_i),
    .reg_index_i       (reg_index_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .read_data_o       (read_data_o),
    .frame_ok_o        (frame_ok_o),
    .led1_on_o         (led1_on_o),
    .led2_on_o         (led2_on_o),
    .beep_start_o      (beep_start_o),
    .mirrors_cleared_o (mirrors_cleared_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic res_t predict_parser_result(input request_t r);
    res_t        res;
    int unsigned pos;
    int unsigned len;
    res = '0;
    case (r.kind)
      KindByte: begin
        pos = rx_count;
        if (pos < BufDepth) begin
          if (pos == 0) begin
            if (r.data == StxByte) rx_flags |= FlagHead;
          end else begin
            if (pos == 1) rx_len = r.data;
            if (pos == 2) rx_card = r.data;
            if (pos >= 4 && pos <= 9) rx_pay[pos - 4] = r.data;
            len = rx_len;
            if (len >= 4) begin
              if (pos <= len - 3) rx_xor ^= r.data;
              if (pos == len - 2 && rx_xor == r.data) rx_flags |= FlagSum;
              if (pos == len - 1 && r.data == EtxByte) rx_flags |= FlagTail;
            end
          end
          rx_count = pos + 1;
        end
      end
      KindEof: begin
        res.frame_ok = rx_count >= 4 && rx_len >= 4 && rx_len <= rx_count &&
                       rx_flags == FlagAll;
        rx_count = 0;
        rx_len   = '0;
        rx_xor   = '0;
        rx_flags = '0;
        if (res.frame_ok) begin
          case (rx_card) inside
            CardProx: begin
              tag_mirror[ProxBase + WType] = WordPresent;
              tag_mirror[ProxBase + WAux]  = {8'h00, rx_pay[1]};
              tag_mirror[ProxBase + WHi]   = {rx_pay[2], rx_pay[3]};
              tag_mirror[ProxBase + WLo]   = {rx_pay[4], rx_pay[5]};
              tag_mirror[WType] = WordProxType;
              tag_mirror[WAux]  = tag_mirror[ProxBase + WAux];
              tag_mirror[WHi]   = tag_mirror[ProxBase + WHi];
              tag_mirror[WLo]   = tag_mirror[ProxBase + WLo];
              led_state = '0;
              led_state[Led1Bit] = 1'b1;
            end
            CardIcA, CardIcB: begin
              tag_mirror[IcBase + WType] = WordPresent;
              tag_mirror[IcBase + WAux]  = '0;
              tag_mirror[IcBase + WHi]   = {rx_pay[1], rx_pay[2]};
              tag_mirror[IcBase + WLo]   = {rx_pay[3], rx_pay[4]};
              tag_mirror[WType] = WordIcType;
              tag_mirror[WAux]  = '0;
              tag_mirror[WHi]   = tag_mirror[IcBase + WHi];
              tag_mirror[WLo]   = tag_mirror[IcBase + WLo];
              led_state[Led2Bit] = 1'b1;
            end
            CardGen10, CardGen11, CardGen20, CardGen21, CardGen22,
            CardGen30, CardGen50, CardGen51, CardGenFf: begin
              tag_mirror[WType] = {8'h00, rx_card};
              tag_mirror[WHi]   = {rx_pay[0], rx_pay[1]};
              tag_mirror[WLo]   = {rx_pay[2], rx_pay[3]};
            end
            default: ;
          endcase
          hold_elapsed = '0;
          hold_on = 1'b1;
          res.beep_start = 1'b1;
        end
      end
      KindTick: begin
        if (hold_on) begin
          if (hold_elapsed != 16'hFFFF) hold_elapsed++;
          if (hold_elapsed >= hold_limit) begin
            foreach (tag_mirror[w]) tag_mirror[w] = '0;
            led_state = '0;
            hold_on = 1'b0;
            res.mirrors_cleared = 1'b1;
          end
        end
      end
      KindRead: begin
        if (r.idx <= RegGenLast) begin
          res.read_data = tag_mirror[r.idx];
        end else if (r.idx >= RegMirFirst && r.idx <= RegMirLast) begin
          res.read_data = tag_mirror[r.idx - RegMirOffset];
        end
      end
      default: ;
    endcase
    res.led1_on = led_state[Led1Bit];
    res.led2_on = led_state[Led2Bit];
    return res;
  endfunction

  task automatic log_error(input string msg);
    error_count++;
    $display("%0t ERROR %s", $time, msg);
  endtask

  task automatic compare_field(input string field, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want) log_error($sformatf("%s got %h want %h", field, got, want));
  endtask

  task automatic add_request(input kind_e k, input logic [7:0] b);
    request_t r;
    r = '0;
    r.kind = k;
    r.data = b;
    r.idx  = 5'($urandom_range(0, 31));
    request_q.push_back(r);
  endtask

  task automatic queue_traffic();
    logic [7:0]  fbytes [$];
    logic [7:0]  sum;
    int unsigned sel;
    int unsigned len;
    int unsigned keep;
    int unsigned pos;
    sel = $urandom_range(0, 99);
    if (sel < 88) begin
      len = ($urandom_range(0, 9) < 7) ? $urandom_range(11, 16) : $urandom_range(4, BufDepth);
      for (pos = 0; pos < len; pos++) fbytes.push_back(8'($urandom));
      fbytes[0] = StxByte;
      fbytes[1] = 8'(len);
      case ($urandom_range(0, 4))
        0: fbytes[2] = CardProx;
        1: fbytes[2] = CardIcA;
        2: fbytes[2] = CardIcB;
        3: fbytes[2] = other_cards[$urandom_range(0, 8)];
        default: ;
      endcase
      sum = '0;
      for (pos = 1; pos + 3 <= len; pos++) sum ^= fbytes[pos];
      fbytes[len - 2] = sum;
      fbytes[len - 1] = EtxByte;
      if (sel >= 60 && sel < 70) begin
        pos = $urandom_range(0, len - 1);
        fbytes[pos] ^= 8'h01 << $urandom_range(0, 7);
      end else if (sel >= 70 && sel < 76) begin
        fbytes[1] = 8'($urandom_range(0, 3));
      end else if (sel >= 76 && sel < 82) begin
        keep = $urandom_range(2, len - 1);
        while (fbytes.size() > keep) void'(fbytes.pop_back());
      end else if (sel >= 82) begin
        if ($urandom_range(0, 1) != 0) fbytes[1] = 8'($urandom_range(BufDepth + 1, 255));
        keep = $urandom_range(BufDepth + 1, BufDepth + 8);
        while (fbytes.size() < keep) fbytes.push_back(8'($urandom));
      end
      foreach (fbytes[i]) begin
        if ($urandom_range(0, 19) == 0) begin
          add_request(($urandom_range(0, 1) != 0) ? KindTick : KindRead, 8'($urandom));
        end
        add_request(KindByte, fbytes[i]);
      end
      if ($urandom_range(0, 19) != 0) add_request(KindEof, 8'($urandom));
      repeat ($urandom_range(0, 3)) add_request(KindRead, 8'($urandom));
      repeat ($urandom_range(0, 12)) add_request(KindTick, 8'($urandom));
    end else if (sel < 94) begin
      repeat ($urandom_range(1, 6)) add_request(kind_e'($urandom_range(0, 3)), 8'($urandom));
    end else begin
      repeat ($urandom_range(1, 48)) add_request(KindTick, 8'($urandom));
      repeat ($urandom_range(1, 4)) add_request(KindRead, 8'($urandom));
    end
  endtask

  task automatic send_request(input request_t r);
    res_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= r.kind;
    rx_byte_i   <= r.data;
    reg_index_i <= r.idx;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = predict_parser_result(r);
    pending_results.push_back(r.typed ? r.want : predicted);
  endtask

  task automatic settle();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_hold_limit(input logic [15:0] ticks);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= ticks;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    hold_limit = ticks;
  endtask

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else if (stall_req != 0) begin
      out_ready_i <= 1'b0;
      stall_left = stall_req;
      stall_req = 0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        log_error("result with nothing pending");
      end else begin
        head_result = pending_results.pop_front();
        compare_field("read_data", read_data_o, head_result.read_data);
        compare_field("frame_ok", frame_ok_o, head_result.frame_ok);
        compare_field("led1_on", led1_on_o, head_result.led1_on);
        compare_field("led2_on", led2_on_o, head_result.led2_on);
        compare_field("beep_start", beep_start_o, head_result.beep_start);
        compare_field("mirrors_cleared", mirrors_cleared_o, head_result.mirrors_cleared);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("card_frame_parser_tag_registers verification failed");
    $finish;
  end

  initial begin
    int unsigned phase;
    int unsigned n;
    logic [15:0] next_limit;
    rx_count = 0;
    rx_len   = '0;
    rx_xor   = '0;
    rx_card  = '0;
    rx_flags = '0;
    foreach (rx_pay[p]) rx_pay[p] = '0;
    foreach (tag_mirror[w]) tag_mirror[w] = '0;
    led_state    = '0;
    hold_on      = 1'b0;
    hold_elapsed = '0;
    hold_limit   = HoldTicksReset;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_hold_limit(16'h0000);
    for (n = 0; n < DirRows; n++) send_request(dir_table[n]);
    in_valid_i <= 1'b0;
    settle();

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 34;
          recv_idle_pct = 45;
          next_limit = 16'($urandom_range(1, 40));
        end
        1: begin
          send_idle_pct = 45;
          recv_idle_pct = 34;
          next_limit = 16'hFFFF;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          next_limit = 16'($urandom_range(0, 3));
        end
      endcase
      set_hold_limit(next_limit);
      while (request_q.size() < RandPerPhase) queue_traffic();
      if (phase == 0) stall_req = 80;
      for (n = 0; request_q.size() != 0; n++) begin
        if (n == RandPerPhase / 2) begin
          in_valid_i <= 1'b0;
          @(posedge clk_i);
          while (pending_results.size() != 0) @(posedge clk_i);
        end
        send_request(request_q.pop_front());
      end
      in_valid_i <= 1'b0;
      settle();
    end

    if (error_count == 0) begin
      $display("card_frame_parser_tag_registers verification clean");
    end else begin
      $display("card_frame_parser_tag_registers verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/cfp_pkg.sv
design/cfp_rx.sv
design/cfp_mirror.sv
design/card_frame_parser_tag_registers.sv
dv/card_frame_parser_tag_registers_tb.sv
